@@ hdl/mae_pkg.sv @@
// Shared types, constants and codes of the matrix add/multiply engine.
`timescale 1ns / 1ps

package mae_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_SIDE_DEF  = 8;
  localparam int DATA_BITS_DEF = 16;

  // Fixed field widths
  localparam int IDX_BITS    = 3;   // row / column index of one element
  localparam int DIM_BITS    = 4;   // shape registers
  localparam int VALUE_BITS  = 16;  // Q8.8 element on the input
  localparam int RESULT_BITS = 32;  // Q16.16 result
  localparam int FRAC_SHIFT  = 8;   // Q8.8 sum -> Q16.16

  localparam logic [RESULT_BITS-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [RESULT_BITS-1:0] SAT_MIN = 32'h8000_0000;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_ADD    = 2'd2,
    OP_MUL    = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_COLS_A = 2'd1,
    CFG_ROWS_B = 2'd2,
    CFG_COLS_B = 2'd3
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT,
    ST_STATUS
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic                load_a;
    logic                load_b;
    logic                issue;
    logic                first;
    logic                last;
    logic                mul;
    logic [IDX_BITS-1:0] r;
    logic [IDX_BITS-1:0] c;
    logic [IDX_BITS-1:0] k;
    logic                out_load;
    logic                out_status;
    logic                out_last;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/mae_in_if.sv @@
// Input channel: load and command items.
`timescale 1ns / 1ps

interface mae_in_if;
  logic                                 valid;
  logic                                 ready;
  mae_pkg::op_t                         op;
  logic [mae_pkg::IDX_BITS-1:0]         row;
  logic [mae_pkg::IDX_BITS-1:0]         col;
  logic signed [mae_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output op, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input op, input row, input col, input value,
                  output ready);
endinterface

@@ hdl/mae_out_if.sv @@
// Output channel: result elements and status items.
`timescale 1ns / 1ps

interface mae_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  status;
  logic [mae_pkg::IDX_BITS-1:0]          out_row;
  logic [mae_pkg::IDX_BITS-1:0]          out_col;
  logic signed [mae_pkg::RESULT_BITS-1:0] result;
  logic                                  last;

  modport source (output valid, output status, output out_row, output out_col,
                  output result, output last, input ready);
  modport sink   (input valid, input status, input out_row, input out_col,
                  input result, input last, output ready);
endinterface

@@ hdl/mae_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mae_ram #(
  parameter int WIDTH = mae_pkg::VALUE_BITS,
  parameter int DEPTH = mae_pkg::MAX_SIDE_DEF * mae_pkg::MAX_SIDE_DEF
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/mae_ctrl.sv @@
// Controller: shape registers, conformance check and element/term sequencing.
`timescale 1ns / 1ps

module mae_ctrl #(
  parameter int MAX_SIDE = mae_pkg::MAX_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  mae_pkg::cfg_idx_t                cfg_idx,
  input  logic [mae_pkg::DIM_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mae_pkg::op_t                     in_op,
  input  logic [mae_pkg::IDX_BITS-1:0]     in_row,
  input  logic [mae_pkg::IDX_BITS-1:0]     in_col,
  input  mae_pkg::dp_stat_t                stat,
  output mae_pkg::cmd_t                    cmd
);

  localparam logic [mae_pkg::DIM_BITS-1:0] SIDE = mae_pkg::DIM_BITS'(MAX_SIDE);

  mae_pkg::state_t state, state_next;

  logic [mae_pkg::DIM_BITS-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [mae_pkg::DIM_BITS-1:0] kmax, cmax, rmax;
  logic                         mul;
  logic [mae_pkg::IDX_BITS-1:0] r, c, k;

  logic add_ok, mul_ok, run_ok, in_compute, in_load_ok;
  logic k_last, c_last, r_last, elem_final;

  function automatic logic dim_ok(input logic [mae_pkg::DIM_BITS-1:0] d);
    dim_ok = (d != '0) && (d <= SIDE);
  endfunction

  // Shape checks
  assign add_ok = dim_ok(rows_a) && dim_ok(cols_a) && (rows_a == rows_b) &&
                  (cols_a == cols_b);
  assign mul_ok = dim_ok(rows_a) && dim_ok(cols_a) && dim_ok(cols_b) &&
                  (cols_a == rows_b);
  assign run_ok = (in_op == mae_pkg::OP_MUL) ? mul_ok : add_ok;

  assign in_compute = in_valid && (in_op == mae_pkg::OP_ADD || in_op == mae_pkg::OP_MUL);
  assign in_load_ok = ({1'b0, in_row} < SIDE) && ({1'b0, in_col} < SIDE);

  // Loop ends
  assign k_last     = ({1'b0, k} + 4'd1) == kmax;
  assign c_last     = ({1'b0, c} + 4'd1) == cmax;
  assign r_last     = ({1'b0, r} + 4'd1) == rmax;
  assign elem_final = r_last && c_last;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mae_pkg::ST_IDLE: begin
        if (in_compute) begin
          state_next = run_ok ? mae_pkg::ST_RUN : mae_pkg::ST_STATUS;
        end
      end
      mae_pkg::ST_RUN: begin
        if (k_last) begin
          state_next = mae_pkg::ST_DRAIN;
        end
      end
      mae_pkg::ST_DRAIN: begin
        if (stat.acc_done) begin
          state_next = mae_pkg::ST_EMIT;
        end
      end
      mae_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_next = elem_final ? mae_pkg::ST_IDLE : mae_pkg::ST_RUN;
        end
      end
      mae_pkg::ST_STATUS: begin
        if (stat.out_free) begin
          state_next = mae_pkg::ST_IDLE;
        end
      end
      default: state_next = mae_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul        = mul;
    cmd.r          = r;
    cmd.c          = c;
    cmd.k          = k;
    unique case (state)
      mae_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_load_ok) begin
          unique case (in_op) inside
            mae_pkg::OP_LOAD_A: cmd.load_a = 1'b1;
            mae_pkg::OP_LOAD_B: cmd.load_b = 1'b1;
            mae_pkg::OP_ADD, mae_pkg::OP_MUL: ;
            default: ;
          endcase
        end
      end
      mae_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
        cmd.first = (k == '0);
        cmd.last  = k_last;
      end
      mae_pkg::ST_DRAIN: ;
      mae_pkg::ST_EMIT: begin
        cmd.out_load = stat.out_free;
        cmd.out_last = elem_final;
      end
      mae_pkg::ST_STATUS: begin
        cmd.out_load   = stat.out_free;
        cmd.out_status = 1'b1;
        cmd.out_last   = 1'b1;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mae_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shape registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= '0;
      cols_a <= '0;
      rows_b <= '0;
      cols_b <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mae_pkg::CFG_ROWS_A: rows_a <= cfg_data;
        mae_pkg::CFG_COLS_A: cols_a <= cfg_data;
        mae_pkg::CFG_ROWS_B: rows_b <= cfg_data;
        mae_pkg::CFG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run setup and element / term counters
  always_ff @(posedge clk) begin
    if (rst) begin
      mul  <= 1'b0;
      kmax <= '0;
      cmax <= '0;
      rmax <= '0;
      r    <= '0;
      c    <= '0;
      k    <= '0;
    end else begin
      unique case (state)
        mae_pkg::ST_IDLE: begin
          if (in_compute) begin
            mul  <= (in_op == mae_pkg::OP_MUL);
            kmax <= (in_op == mae_pkg::OP_MUL) ? cols_a : 4'd1;
            cmax <= (in_op == mae_pkg::OP_MUL) ? cols_b : cols_a;
            rmax <= rows_a;
            r    <= '0;
            c    <= '0;
            k    <= '0;
          end
        end
        mae_pkg::ST_RUN: begin
          k <= k_last ? '0 : k + 3'd1;
        end
        mae_pkg::ST_EMIT: begin
          if (stat.out_free) begin
            if (c_last) begin
              c <= '0;
              r <= r + 3'd1;
            end else begin
              c <= c + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/mae_dp.sv @@
// Datapath: element stores, shared multiply-accumulate, saturation, output register.
`timescale 1ns / 1ps

module mae_dp #(
  parameter int MAX_SIDE  = mae_pkg::MAX_SIDE_DEF,
  parameter int DATA_BITS = mae_pkg::DATA_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mae_pkg::cmd_t                          cmd,
  output mae_pkg::dp_stat_t                      stat,
  input  logic [mae_pkg::IDX_BITS-1:0]           ld_row,
  input  logic [mae_pkg::IDX_BITS-1:0]           ld_col,
  input  logic signed [mae_pkg::VALUE_BITS-1:0]  ld_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_status,
  output logic [mae_pkg::IDX_BITS-1:0]           out_row,
  output logic [mae_pkg::IDX_BITS-1:0]           out_col,
  output logic signed [mae_pkg::RESULT_BITS-1:0] out_result,
  output logic                                   out_last
);

  localparam int EW        = (DATA_BITS < mae_pkg::VALUE_BITS) ? DATA_BITS
                                                               : mae_pkg::VALUE_BITS;
  localparam int ADD_BITS  = EW + 1 + mae_pkg::FRAC_SHIFT;
  localparam int PROD_BITS = (2 * EW > ADD_BITS) ? 2 * EW : ADD_BITS;
  localparam int SUM_BITS  = PROD_BITS + $clog2(MAX_SIDE) + 1;
  localparam int ACC_BITS  = (SUM_BITS > mae_pkg::RESULT_BITS) ? SUM_BITS
                                                               : mae_pkg::RESULT_BITS + 1;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RB        = mae_pkg::RESULT_BITS;

  function automatic logic [AW-1:0] addr_of(input logic [mae_pkg::IDX_BITS-1:0] rr,
                                            input logic [mae_pkg::IDX_BITS-1:0] cc);
    addr_of = AW'(int'(rr) * MAX_SIDE + int'(cc));
  endfunction

  logic [AW-1:0]               wr_addr, rd_addr_a, rd_addr_b;
  logic [EW-1:0]               elem;
  logic signed [EW-1:0]        a_q, b_q;
  logic signed [2*EW-1:0]      mul_full;
  logic signed [EW:0]          sum_ab;
  logic signed [ADD_BITS-1:0]  add_shift;
  logic signed [PROD_BITS-1:0] prod_in, prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic [ACC_BITS-RB:0]        acc_hi;
  logic [RB-1:0]               sat;

  logic s1_valid, s1_first, s1_last, s1_mul;
  logic s2_valid, s2_first, s2_last;
  logic acc_done;

  // Element stores; the low bits of a load carry the element
  assign elem      = ld_value[EW-1:0];
  assign wr_addr   = addr_of(ld_row, ld_col);
  assign rd_addr_a = cmd.mul ? addr_of(cmd.r, cmd.k) : addr_of(cmd.r, cmd.c);
  assign rd_addr_b = cmd.mul ? addr_of(cmd.k, cmd.c) : addr_of(cmd.r, cmd.c);

  mae_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.load_a),
    .waddr (wr_addr),
    .wdata (elem),
    .re    (cmd.issue),
    .raddr (rd_addr_a),
    .rdata (a_q)
  );

  mae_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.load_b),
    .waddr (wr_addr),
    .wdata (elem),
    .re    (cmd.issue),
    .raddr (rd_addr_b),
    .rdata (b_q)
  );

  // Term: a*b for multiply, (a+b) scaled to Q16.16 for add
  assign mul_full  = a_q * b_q;
  assign sum_ab    = (EW+1)'(a_q) + (EW+1)'(b_q);
  assign add_shift = {sum_ab, {mae_pkg::FRAC_SHIFT{1'b0}}};
  assign prod_in   = s1_mul ? PROD_BITS'(mul_full) : PROD_BITS'(add_shift);

  // Pipeline control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      acc_done <= s2_valid && s2_last;
    end
  end

  // Pipeline payload: term register and accumulator
  always_ff @(posedge clk) begin
    s1_first <= cmd.first;
    s1_last  <= cmd.last;
    s1_mul   <= cmd.mul;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= prod_in;
    if (s2_valid) begin
      acc <= s2_first ? ACC_BITS'(prod) : acc + ACC_BITS'(prod);
    end
  end

  // Saturate to 32 bits
  assign acc_hi = acc[ACC_BITS-1:RB-1];
  always_comb begin
    if (acc_hi == '0 || acc_hi == '1) begin
      sat = acc[RB-1:0];
    end else begin
      sat = acc[ACC_BITS-1] ? mae_pkg::SAT_MIN : mae_pkg::SAT_MAX;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_row    <= cmd.out_status ? '0 : cmd.r;
      out_col    <= cmd.out_status ? '0 : cmd.c;
      out_result <= cmd.out_status ? '0 : sat;
      out_last   <= cmd.out_last;
    end
  end

  assign stat.acc_done = acc_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

@@ hdl/matrix_add_multiply_engine.sv @@
// Top level of the matrix add/multiply engine.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+------------------------------------------
//   cfg      | in  | cfg_we          | cfg_idx, cfg_data (shape registers)
//   in_ch    | in  | valid / ready   | op, row, col, value (Q8.8)
//   out_ch   | out | valid / ready   | status, out_row, out_col, result, last
//
// A load is written into its store as it is accepted. A run first latches its
// loop bounds, then each result element is built from K terms on the single
// multiply-accumulate unit (K = cols_a for multiply, 1 for add), passing through
// RAM read, term register, accumulate and output load. A shape mismatch loads
// its status item into the output register from the status state, once free.
// Reset is synchronous; the element stores are not cleared. A stalled output
// holds the run at the next element; the input takes a new item while the
// final result of the previous run still waits.
`timescale 1ns / 1ps

module matrix_add_multiply_engine #(
  parameter int MAX_SIDE  = mae_pkg::MAX_SIDE_DEF,
  parameter int DATA_BITS = mae_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  mae_pkg::cfg_idx_t            cfg_idx,
  input  logic [mae_pkg::DIM_BITS-1:0] cfg_data,
  mae_in_if.sink                       in_ch,
  mae_out_if.source                    out_ch
);

  mae_pkg::cmd_t     cmd;
  mae_pkg::dp_stat_t stat;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  // Sequencing
  mae_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_op    (in_ch.op),
    .in_row   (in_ch.row),
    .in_col   (in_ch.col),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, arithmetic and output register
  mae_dp #(.MAX_SIDE(MAX_SIDE), .DATA_BITS(DATA_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .ld_row     (in_ch.row),
    .ld_col     (in_ch.col),
    .ld_value   (in_ch.value),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_row    (out_ch.out_row),
    .out_col    (out_ch.out_col),
    .out_result (out_ch.result),
    .out_last   (out_ch.last)
  );

endmodule

@@ hdl/mae_checker.sv @@
// Port-level checks of the matrix add/multiply engine, bound to the top level.
`timescale 1ns / 1ps

module mae_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input mae_pkg::op_t                           in_op,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic                                   out_status,
  input logic [mae_pkg::IDX_BITS-1:0]           out_row,
  input logic [mae_pkg::IDX_BITS-1:0]           out_col,
  input logic signed [mae_pkg::RESULT_BITS-1:0] out_result,
  input logic                                   out_last
);

  logic       run_acc, last_acc;
  logic [1:0] pending;

  assign run_acc  = in_valid && in_ready &&
                    (in_op == mae_pkg::OP_ADD || in_op == mae_pkg::OP_MUL);
  assign last_acc = out_valid && out_ready && out_last;

  // Runs started whose final item has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, run_acc} - {1'b0, last_acc};
    end
  end

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_row) &&
      $stable(out_col) && $stable(out_result) && $stable(out_last))
    else $error("output item changed while stalled");

  // Status item shape
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status |-> out_last && out_row == '0 && out_col == '0 &&
      out_result == '0)
    else $error("malformed status item");

  // No result item without a run behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result item without a run");

  // A new run starts only once the previous run has no more than its last item left
  a_one_ahead: assert property (@(posedge clk) disable iff (rst)
    run_acc |-> pending == 2'd0 || (pending == 2'd1 && out_valid && out_last))
    else $error("run accepted while previous run still computing");

  // A run command closes the input for the next cycle
  a_busy_after_run: assert property (@(posedge clk) disable iff (rst)
    run_acc |=> !in_ready)
    else $error("input ready right after a run command");

endmodule

bind matrix_add_multiply_engine mae_checker u_mae_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_row    (out_ch.out_row),
  .out_col    (out_ch.out_col),
  .out_result (out_ch.result),
  .out_last   (out_ch.last)
);

@@ tb/tb_matrix_add_multiply_engine.sv @@
// Self-checking testbench for the matrix add/multiply engine.
`timescale 1ns / 1ps

module tb_matrix_add_multiply_engine;
  import mae_pkg::*;

  localparam int SIDE        = MAX_SIDE_DEF;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_MAX   = 50;

  // One result element as the engine should emit it
  typedef struct {
    logic                          status;
    logic [IDX_BITS-1:0]           row;
    logic [IDX_BITS-1:0]           col;
    logic signed [RESULT_BITS-1:0] value;
    logic                          last;
  } elem_t;

  // Output stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_PERIODIC,
    RX_LONG
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  cfg_idx_t              cfg_idx;
  logic [DIM_BITS-1:0]   cfg_data;
  logic                  rx_ready = 1'b0;
  rx_mode_t              rx_mode = RX_FREE;
  logic [7:0]            rx_tick = '0;
  int                    cycle_cnt = 0;
  int                    mismatches = 0;

  // Engine shadow: element stores and shape registers
  logic signed [VALUE_BITS-1:0] mat_a [SIDE][SIDE];
  logic signed [VALUE_BITS-1:0] mat_b [SIDE][SIDE];
  logic [DIM_BITS-1:0]          dim_rows_a = '0;
  logic [DIM_BITS-1:0]          dim_cols_a = '0;
  logic [DIM_BITS-1:0]          dim_rows_b = '0;
  logic [DIM_BITS-1:0]          dim_cols_b = '0;
  elem_t                        pending_elems [$];
  elem_t                        want;

  // Sender pacing
  bit gaps_on    = 1'b0;
  int burst_left = 0;

  mae_in_if  in_ch ();
  mae_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  matrix_add_multiply_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output stalls: a new pattern is drawn whenever rx_tick[5:0] is zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:     rx_ready <= 1'b1;
      RX_COIN:     rx_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: rx_ready <= (rx_tick[2:0] > 3'd2);
      default:     rx_ready <= (rx_tick[3:0] > 4'd9);  // low while rx_tick[3:0] is 9 or less
    endcase
  end

  function automatic bit side_ok(logic [DIM_BITS-1:0] d);
    return d >= 1 && d <= SIDE;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_MAX) $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  // Work out the result elements of one accepted item
  task automatic predict_item(op_t op, logic [IDX_BITS-1:0] row, logic [IDX_BITS-1:0] col,
                              logic signed [VALUE_BITS-1:0] value);
    elem_t  e;
    longint acc;
    int     n_cols;
    bit     fits;
    case (op)
      OP_LOAD_A: mat_a[row][col] = value;
      OP_LOAD_B: mat_b[row][col] = value;
      default: begin
        if (op == OP_ADD) begin
          fits = side_ok(dim_rows_a) && side_ok(dim_cols_a) &&
                 dim_rows_a == dim_rows_b && dim_cols_a == dim_cols_b;
          n_cols = dim_cols_a;
        end else begin
          fits = side_ok(dim_rows_a) && side_ok(dim_cols_a) && side_ok(dim_cols_b) &&
                 dim_cols_a == dim_rows_b;
          n_cols = dim_cols_b;
        end
        if (!fits) begin
          e = '{status: 1'b1, row: '0, col: '0, value: '0, last: 1'b1};
          pending_elems.push_back(e);
        end else begin
          for (int r = 0; r < dim_rows_a; r++) begin
            for (int c = 0; c < n_cols; c++) begin
              acc = 0;
              if (op == OP_ADD) begin
                // Q8.8 sum moved up to Q16.16
                acc = (longint'(mat_a[r][c]) + longint'(mat_b[r][c])) <<< FRAC_SHIFT;
              end else begin
                for (int k = 0; k < dim_cols_a; k++)
                  acc += longint'(mat_a[r][k]) * longint'(mat_b[k][c]);
              end
              e.status = 1'b0;
              e.row    = IDX_BITS'(r);
              e.col    = IDX_BITS'(c);
              if (acc > 64'sd2147483647) e.value = SAT_MAX;
              else if (acc < -64'sd2147483648) e.value = SAT_MIN;
              else e.value = acc[RESULT_BITS-1:0];
              e.last = (r == dim_rows_a - 1) && (c == n_cols - 1);
              pending_elems.push_back(e);
            end
          end
        end
      end
    endcase
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_elems.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected (row %0d col %0d)",
                                  out_ch.out_row, out_ch.out_col));
      end else begin
        want = pending_elems.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %b, want %b", out_ch.status, want.status));
        if (out_ch.out_row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_ch.out_row, want.row));
        if (out_ch.out_col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_ch.out_col, want.col));
        if (out_ch.result !== want.value)
          report_mismatch($sformatf("result %h, want %h at (%0d,%0d)",
                                    out_ch.result, want.value, want.row, want.col));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %b, want %b at (%0d,%0d)",
                                    out_ch.last, want.last, want.row, want.col));
      end
    end
  end

  // Insert a gap after a burst; valid stays high inside a burst
  task automatic pace_sender();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk);
    burst_left = $urandom_range(0, 10);
  endtask

  // Present one item and hold it until the engine takes it
  task automatic send_item(op_t op, logic [IDX_BITS-1:0] row, logic [IDX_BITS-1:0] col,
                           logic signed [VALUE_BITS-1:0] value);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.row   <= row;
    in_ch.col   <= col;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, row, col, value);
    pace_sender();
  endtask

  // Stop sending and wait until every expected result is in
  task automatic drain_results(int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DIM_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_ROWS_A: dim_rows_a = data;
      CFG_COLS_A: dim_cols_a = data;
      CFG_ROWS_B: dim_rows_b = data;
      CFG_COLS_B: dim_cols_b = data;
    endcase
  endtask

  // New shapes, written only once the engine is idle
  task automatic set_shape(logic [DIM_BITS-1:0] ra, logic [DIM_BITS-1:0] ca,
                           logic [DIM_BITS-1:0] rb, logic [DIM_BITS-1:0] cb);
    drain_results(SETTLE);
    write_reg(CFG_ROWS_A, ra);
    write_reg(CFG_COLS_A, ca);
    write_reg(CFG_ROWS_B, rb);
    write_reg(CFG_COLS_B, cb);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Shapes still zero after reset: both commands are refused
  task automatic test_unconfigured();
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MUL, '0, '0, '0);
  endtask

  // Write every entry of both stores, with the value extremes in the corners
  task automatic test_fill_stores();
    logic signed [VALUE_BITS-1:0] va;
    logic signed [VALUE_BITS-1:0] vb;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        va = VALUE_BITS'($urandom);
        vb = VALUE_BITS'($urandom);
        if (r == 0 && c == 0) begin
          va = 16'sh7FFF;
          vb = 16'sh8000;
        end else if (r == SIDE - 1 && c == SIDE - 1) begin
          va = 16'sh8000;
          vb = 16'sh7FFF;
        end
        send_item(OP_LOAD_A, IDX_BITS'(r), IDX_BITS'(c), va);
        send_item(OP_LOAD_B, IDX_BITS'(r), IDX_BITS'(c), vb);
      end
    end
  endtask

  // Largest shapes for both commands
  task automatic test_full_size();
    set_shape(4'd8, 4'd8, 4'd8, 4'd8);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MUL, '0, '0, '0);
  endtask

  // Zero and oversize dimensions, and shapes that fit only one command
  task automatic test_bad_shapes();
    set_shape(4'd9, 4'd9, 4'd9, 4'd9);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MUL, '0, '0, '0);
    set_shape(4'd15, 4'd8, 4'd8, 4'd15);
    send_item(OP_MUL, '0, '0, '0);
    set_shape(4'd8, 4'd0, 4'd8, 4'd0);
    send_item(OP_ADD, '0, '0, '0);
    // add refused, multiply fits
    set_shape(4'd2, 4'd3, 4'd3, 4'd2);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MUL, '0, '0, '0);
    // add fits, multiply refused
    set_shape(4'd3, 4'd2, 4'd3, 4'd2);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MUL, '0, '0, '0);
  endtask

  // Sums of products beyond Q16.16 saturate both ways
  task automatic test_mul_saturation();
    set_shape(4'd2, 4'd4, 4'd4, 4'd1);
    for (int k = 0; k < 4; k++) begin
      send_item(OP_LOAD_A, 3'd0, IDX_BITS'(k), 16'sh8000);
      send_item(OP_LOAD_A, 3'd1, IDX_BITS'(k), 16'sh7FFF);
      send_item(OP_LOAD_B, IDX_BITS'(k), 3'd0, 16'sh8000);
    end
    send_item(OP_MUL, '0, '0, '0);
  endtask

  // Dot product, outer product and single elements
  task automatic test_vector_shapes();
    set_shape(4'd1, 4'd8, 4'd8, 4'd1);
    send_item(OP_MUL, '0, '0, '0);
    set_shape(4'd8, 4'd1, 4'd1, 4'd8);
    send_item(OP_MUL, '0, '0, '0);
    set_shape(4'd1, 4'd1, 4'd1, 4'd1);
    send_item(OP_ADD, '0, '0, '0);
    send_item(OP_MUL, '0, '0, '0);
  endtask

  // Phases of random shapes, each a run of loads mixed with commands
  task automatic test_random(int n_items);
    int                  sent;
    int                  len;
    int                  pick;
    int                  rl;
    int                  cl;
    op_t                 op;
    logic [DIM_BITS-1:0] ra;
    logic [DIM_BITS-1:0] ca;
    logic [DIM_BITS-1:0] rb;
    logic [DIM_BITS-1:0] cb;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      ra = DIM_BITS'($urandom_range(1, 4));
      ca = DIM_BITS'($urandom_range(1, 4));
      if (pick < 4) begin
        rb = ca;
        cb = DIM_BITS'($urandom_range(1, 4));
      end else if (pick < 7) begin
        rb = ra;
        cb = ca;
      end else if (pick == 7) begin
        ra = 4'd8;
        ca = DIM_BITS'($urandom_range(1, 8));
        rb = ca;
        cb = DIM_BITS'($urandom_range(1, 8));
      end else begin
        ra = DIM_BITS'($urandom_range(0, 15));
        ca = DIM_BITS'($urandom_range(0, 15));
        rb = DIM_BITS'($urandom_range(0, 15));
        cb = DIM_BITS'($urandom_range(0, 15));
      end
      set_shape(ra, ca, rb, cb);
      gaps_on = ($urandom_range(0, 2) != 0);
      len = $urandom_range(6, 20);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // loads mostly land inside the shape in use
          if (pick < 4) begin
            op = OP_LOAD_A;
            rl = ra;
            cl = ca;
          end else begin
            op = OP_LOAD_B;
            rl = rb;
            cl = cb;
          end
          if (!side_ok(DIM_BITS'(rl)) || !side_ok(DIM_BITS'(cl)) ||
              $urandom_range(0, 3) == 0) begin
            rl = SIDE;
            cl = SIDE;
          end
          send_item(op, IDX_BITS'($urandom_range(0, rl - 1)),
                    IDX_BITS'($urandom_range(0, cl - 1)), pick_value());
        end else begin
          op = (pick == 7) ? OP_ADD : OP_MUL;
          send_item(op, IDX_BITS'($urandom), IDX_BITS'($urandom), VALUE_BITS'($urandom));
        end
        sent++;
        // now and then hold off until the engine has caught up
        if ($urandom_range(0, 24) == 0) drain_results(0);
      end
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_ROWS_A;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_LOAD_A;
    in_ch.row   <= '0;
    in_ch.col   <= '0;
    in_ch.value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_unconfigured();
    gaps_on = 1'b1;
    test_fill_stores();
    test_full_size();
    gaps_on = 1'b0;
    test_bad_shapes();
    gaps_on = 1'b1;
    test_mul_saturation();
    test_vector_shapes();
    test_random(50);

    drain_results(4 * SETTLE);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ matrix_add_multiply_engine.f @@
hdl/mae_pkg.sv
hdl/mae_in_if.sv
hdl/mae_out_if.sv
hdl/mae_ram.sv
hdl/mae_ctrl.sv
hdl/mae_dp.sv
hdl/matrix_add_multiply_engine.sv
hdl/mae_checker.sv
tb/tb_matrix_add_multiply_engine.sv
